// ===== rtl/core/window_product_string_hash_assert.svh =====
// Assertion macros used by the checker of the window product string hash.
`ifndef WINDOW_PRODUCT_STRING_HASH_ASSERT_SVH
`define WINDOW_PRODUCT_STRING_HASH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPSH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WPSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wpsh_pkg.sv =====
// Package with the widths and types of the window product string hash.
package wpsh_pkg;

  // Character and hash word widths.
  localparam int CH_W   = 8;
  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic signed [CH_W-1:0] ch_t;

endpackage

// ===== rtl/core/window_product_string_hash.sv =====
// Top level of the window product string hash: input stage, window products, result register.
//
//   channel | direction | transaction payload
//   --------+-----------+-------------------------------
//   in_     | input     | in_ch (signed 8), in_last
//   out_    | output    | out_hash_value (32), one per string
//
// One character is taken every cycle unless in_stall holds it; a hash goes from the input stage
// into the result register. The rate is set by the single compute stage: one 32 by 8 multiply
// per held run product and one adder over the fresh products and the running sum.
// Reset clears the stage valids, the held products and the running sum.
// The input stalls only while a last character waits behind a result that is held by out_stall.
module window_product_string_hash import wpsh_pkg::*; #(
  parameter int MAX_RUN = 6
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  ch_t   in_ch,
  input  logic  in_last,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t out_hash_value
);

  localparam int RUN_DEPTH = (MAX_RUN > 1) ? MAX_RUN - 1 : 1;

  // Input stage registers.
  logic  s1_valid_r;
  logic  s1_valid_nxt;
  ch_t   s1_ch_r;
  logic  s1_last_r;

  // Held products of the runs ending at the latest character, and the running sum.
  word_t run_r   [RUN_DEPTH];
  word_t run_nxt [RUN_DEPTH];
  word_t hash_r;
  word_t hash_nxt;

  // Result register.
  logic  out_valid_r;
  logic  out_valid_nxt;
  word_t out_hash_r;

  logic  in_accept;
  logic  s1_block;
  logic  s1_fire;
  word_t c_ext;
  word_t fresh [MAX_RUN];
  word_t sum_all;

  // Handshake: only a last character can be held back, by a waiting result.
  assign s1_block  = s1_last_r && out_valid_r && out_stall;
  assign s1_fire   = s1_valid_r && !s1_block;
  assign in_stall  = s1_valid_r && s1_block;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  // Fresh window products: each held run product times the new character.
  always_comb begin
    c_ext = {{(WORD_W-CH_W){s1_ch_r[CH_W-1]}}, s1_ch_r};
    fresh[0] = c_ext;
    for (int k = 1; k < MAX_RUN; k++) begin
      fresh[k] = run_r[k-1] * c_ext;
    end
    sum_all = hash_r;
    for (int k = 0; k < MAX_RUN; k++) begin
      sum_all = sum_all + fresh[k];
    end
  end

  // Next state: a last character clears everything for the next string.
  always_comb begin
    hash_nxt = hash_r;
    for (int k = 0; k < RUN_DEPTH; k++) begin
      run_nxt[k] = run_r[k];
    end
    if (s1_fire) begin
      if (s1_last_r || (MAX_RUN == 1)) begin
        for (int k = 0; k < RUN_DEPTH; k++) begin
          run_nxt[k] = '0;
        end
      end else begin
        for (int k = 0; k < RUN_DEPTH; k++) begin
          run_nxt[k] = fresh[k];
        end
      end
      hash_nxt = s1_last_r ? '0 : sum_all;
    end
  end

  // A finished hash enters the result register; otherwise it drains when taken.
  assign out_valid_nxt = (s1_fire && s1_last_r) ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hash_r      <= '0;
      for (int k = 0; k < RUN_DEPTH; k++) begin
        run_r[k] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      hash_r      <= hash_nxt;
      for (int k = 0; k < RUN_DEPTH; k++) begin
        run_r[k] <= run_nxt[k];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
    if (s1_fire && s1_last_r) begin
      out_hash_r <= sum_all;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

// ===== rtl/core/wpsh_checker.sv =====
// Port checker for the window product string hash and its bind to the top level.
`include "window_product_string_hash_assert.svh"

module wpsh_checker import wpsh_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_stall,
  input ch_t   in_ch,
  input logic  in_last,
  input logic  out_valid,
  input logic  out_stall,
  input word_t out_hash_value
);

  logic in_last_accept;

  // A transaction that closes a string.
  assign in_last_accept = in_valid && !in_stall && in_last;

  // A held result keeps its value until it is taken.
  `WPSH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_hash_value), "stalled result changed")

  // The input is only held back by a result that is itself stalled.
  `WPSH_ASSERT_IMPL(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a waiting result")

  // A fresh result follows an accepted last character, through the input stage and the result register.
  `WPSH_ASSERT_IMPL(a_out_latency, clk, rst_n, $rose(out_valid), $past(in_last_accept, 2), "result without a last character")

endmodule

bind window_product_string_hash wpsh_checker u_wpsh_checker (.*);

// ===== dv/window_product_string_hash_tb.sv =====
// Self-checking testbench for the window product string hash: directed table, then random strings.
module window_product_string_hash_tb;
  import wpsh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RUN     = 6;
  localparam int RAND_CHARS  = 1700;
  localparam int IDLE_PCT    = 9;
  localparam int CALM_FIRST  = 500;
  localparam int CALM_LAST   = 800;
  localparam int DRAIN_POINT = 900;
  localparam int TAIL_CYCLES = 10;

  // One row of the directed table; a pinned row carries its hash typed in by hand.
  typedef struct {
    ch_t   ch;
    logic  fin;
    bit    pinned;
    word_t hash;
  } char_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  ch_t   in_ch = '0;
  logic  in_last = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_hash_value;

  // Predictor state: products of the runs ending at the newest character, and the running sum.
  word_t held_runs [MAX_RUN-1];
  word_t running_sum;
  word_t pending_hashes [$];
  int    fault_count = 0;
  bit    calm = 1'b0;

  window_product_string_hash #(.MAX_RUN(MAX_RUN)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_ch         (in_ch),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_value(out_hash_value)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Clear the predicted string state.
  task automatic clear_string();
    foreach (held_runs[k]) held_runs[k] = '0;
    running_sum = '0;
  endtask

  // Fold one character into the predicted state; on the final character return the hash.
  task automatic absorb_char(input ch_t c, input logic fin, output bit emits, output word_t hash);
    word_t widened;
    word_t grown [MAX_RUN];
    word_t total;
    widened  = {{(WORD_W-CH_W){c[CH_W-1]}}, c};
    grown[0] = widened;
    for (int k = 1; k < MAX_RUN; k++) grown[k] = held_runs[k-1] * widened;
    total = running_sum;
    for (int k = 0; k < MAX_RUN; k++) total += grown[k];
    emits = fin;
    hash  = total;
    if (fin) begin
      clear_string();
    end else begin
      for (int k = 0; k < MAX_RUN-1; k++) held_runs[k] = grown[k];
      running_sum = total;
    end
  endtask

  // Offer one character, hold it until the transaction completes, then record the expectation.
  task automatic send_char(input ch_t c, input logic fin, input bit pinned, input word_t pin_hash);
    bit    emits;
    word_t hash;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    in_last  <= fin;
    do @(posedge clk); while (in_stall);
    absorb_char(c, fin, emits, hash);
    if (emits) pending_hashes.push_back(pinned ? pin_hash : hash);
  endtask

  // Random character, leaning towards zero and the extremes.
  function automatic ch_t pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return ch_t'(0);
    if (roll < 15) return ch_t'(-128);
    if (roll < 20) return ch_t'(127);
    if (roll < 25) return ch_t'(-1);
    if (roll < 28) return ch_t'(1);
    return ch_t'($urandom_range(0, 255));
  endfunction

  // Result side stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Compare every completed result transaction with the oldest expected hash.
  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hashes.size() == 0) begin
        $error("out_hash_value: no hash expected, got %h", out_hash_value);
        fault_count++;
      end else begin
        want = pending_hashes.pop_front();
        if (out_hash_value !== want) begin
          $error("out_hash_value: expected %h, got %h", want, out_hash_value);
          fault_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random strings, drain.
  initial begin
    char_row_t plan [$];
    int        sent;
    int        len;
    int        roll;
    bit        drained;
    clear_string();

    // Single characters at the extremes, a short string, overflow, a zero inside a string, a long mixed-sign string.
    plan = '{
      '{ch_t'(127),  1'b1, 1'b1, 32'h0000_007F},
      '{ch_t'(-128), 1'b1, 1'b1, 32'hFFFF_FF80},
      '{ch_t'(0),    1'b1, 1'b1, 32'h0000_0000},
      '{ch_t'(-1),   1'b1, 1'b1, 32'hFFFF_FFFF},
      '{ch_t'(2),    1'b0, 1'b0, 32'h0},
      '{ch_t'(3),    1'b1, 1'b1, 32'h0000_000B},
      '{ch_t'(-128), 1'b0, 1'b0, 32'h0},
      '{ch_t'(-128), 1'b0, 1'b0, 32'h0},
      '{ch_t'(-128), 1'b0, 1'b0, 32'h0},
      '{ch_t'(-128), 1'b0, 1'b0, 32'h0},
      '{ch_t'(-128), 1'b0, 1'b0, 32'h0},
      '{ch_t'(-128), 1'b0, 1'b0, 32'h0},
      '{ch_t'(-128), 1'b1, 1'b0, 32'h0},
      '{ch_t'(5),    1'b0, 1'b0, 32'h0},
      '{ch_t'(0),    1'b0, 1'b0, 32'h0},
      '{ch_t'(7),    1'b1, 1'b1, 32'h0000_000C},
      '{ch_t'(127),  1'b0, 1'b0, 32'h0},
      '{ch_t'(127),  1'b0, 1'b0, 32'h0},
      '{ch_t'(127),  1'b0, 1'b0, 32'h0},
      '{ch_t'(127),  1'b0, 1'b0, 32'h0},
      '{ch_t'(127),  1'b0, 1'b0, 32'h0},
      '{ch_t'(-1),   1'b0, 1'b0, 32'h0},
      '{ch_t'(-1),   1'b1, 1'b0, 32'h0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_char(plan[i].ch, plan[i].fin, plan[i].pinned, plan[i].hash);

    // Random strings, mostly short, some beyond the longest window.
    sent    = 0;
    drained = 1'b0;
    while (sent < RAND_CHARS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) len = $urandom_range(1, 8);
      else if (roll < 90) len = $urandom_range(9, 16);
      else len = $urandom_range(17, 40);
      for (int j = 0; j < len; j++) begin
        calm = (sent >= CALM_FIRST) && (sent < CALM_LAST);
        send_char(pick_char(), j == len - 1, 1'b0, '0);
        sent++;
      end
      // Hold the sender once until every hash so far has come back.
      if (!drained && sent >= DRAIN_POINT) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_hashes.size() != 0);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Let outstanding hashes arrive, then watch for strays.
    do @(posedge clk); while (pending_hashes.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400us;
    $display("Test completed with failures");
    $finish;
  end

endmodule
